### rtl/tlv_parameter_store_top_macros.svh
// Assertion macros used by the tlv parameter store RTL.
`ifndef TLV_PARAMETER_STORE_TOP_MACROS_SVH
`define TLV_PARAMETER_STORE_TOP_MACROS_SVH

`ifndef SYNTH
`define TLVPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlvps: same-cycle check failed");
`define TLVPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlvps: next-cycle check failed");
`else
`define TLVPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TLVPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/tlvps_pkg.sv
`default_nettype none

package tlvps_pkg;

   localparam int MEM_BYTES_DEF = 1024;
   localparam int MAX_TRANSFER = 32;
   localparam logic [7:0] ERASED_TAG = 8'hFF;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_ERASE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tag;
      logic [7:0] param_len;
      logic [7:0] offset;
      logic [5:0] count;
      logic [4:0] byte_index;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] data_res;
      logic [5:0] length;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

### rtl/tlv_parameter_store_top.sv
// Tag/length/value record store on a byte RAM of MEM_BYTES entries.
// Request channel (req_valid / req_stall / req_word): one word per command:
// read, write one byte of a request, or erase. Result channel (rsp_valid /
// rsp_stall / rsp_word): a read returns one word per granted byte (or one empty
// word), a write byte and an erase return one word each; last marks the end.
// Requests are served one at a time; req_stall is high while a request is in
// progress. A lookup walks the record headers from address 0 through the
// single RAM port (S_WALK_T, S_WALK_L, S_WALK_E per header, S_WALK_T alone
// when it runs off the end), then decides in S_DECIDE. A read then alternates
// S_RD_ISSUE and S_RD_PUSH per byte. A write byte passes S_WBYTE and S_PUSH1
// before the next accept, plus the walk and decide on its first byte and
// S_MK_TAG and S_MK_LEN when a record is created. Erase rewrites every byte.
// After reset a pass fills every address with 0xFF while req_stall is high.
// Results sit in an output register: while the receiver stalls, the word holds
// and the next request is still taken, but its results wait for the register.
`default_nettype none

module tlv_parameter_store_top #(
   parameter int MEM_BYTES = tlvps_pkg::MEM_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlvps_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlvps_pkg::rsp_type rsp_word
);

   import tlvps_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);

   mem_ctl_type   mem_ctl;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;
   logic          rsp_load;
   rsp_type       rsp_next;
   logic          rsp_slot_free;

   tlvps_ctrl #(
      .MEM_BYTES(MEM_BYTES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_load     (rsp_load),
      .rsp_next     (rsp_next),
      .rsp_slot_free(rsp_slot_free),
      .mem_ctl      (mem_ctl),
      .mem_addr     (mem_addr),
      .mem_wdata    (mem_wdata),
      .mem_rdata    (mem_rdata)
   );

   tlvps_mem #(
      .MEM_BYTES(MEM_BYTES)
   ) u_mem (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .mem_addr (mem_addr),
      .mem_wdata(mem_wdata),
      .mem_rdata(mem_rdata)
   );

   tlvps_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (rsp_load),
      .next_word(rsp_next),
      .slot_free(rsp_slot_free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

### rtl/tlvps_mem.sv
`default_nettype none

module tlvps_mem #(
   parameter int MEM_BYTES = tlvps_pkg::MEM_BYTES_DEF,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  logic                  clock,
   input  tlvps_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]         mem_addr,
   input  logic [7:0]            mem_wdata,
   output logic [7:0]            mem_rdata
);

   logic [7:0] store_ff [MEM_BYTES];
   logic [7:0] rdata_ff;

   // single port: the controller never reads and writes in one cycle
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_ff[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= store_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/tlvps_out.sv
`default_nettype none

module tlvps_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  tlvps_pkg::rsp_type next_word,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tlvps_pkg::rsp_type rsp_word
);

   logic               valid_ff;
   logic               valid_in;
   tlvps_pkg::rsp_type word_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= next_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

### rtl/tlvps_ctrl.sv
`default_nettype none
`include "tlv_parameter_store_top_macros.svh"

module tlvps_ctrl #(
   parameter int MEM_BYTES = tlvps_pkg::MEM_BYTES_DEF,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tlvps_pkg::req_type     req_word,
   output logic                   rsp_load,
   output tlvps_pkg::rsp_type     rsp_next,
   input  logic                   rsp_slot_free,
   output tlvps_pkg::mem_ctl_type mem_ctl,
   output logic [AW-1:0]          mem_addr,
   output logic [7:0]             mem_wdata,
   input  logic [7:0]             mem_rdata
);

   import tlvps_pkg::*;

   localparam int PW = $clog2(MEM_BYTES + 512);
   localparam logic [PW-1:0] MEM_END = PW'(MEM_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
   localparam logic [5:0] MAX_CNT = 6'(MAX_TRANSFER);

   typedef enum logic [11:0] {
      S_CLEAR    = 12'b0000_0000_0001,
      S_IDLE     = 12'b0000_0000_0010,
      S_WALK_T   = 12'b0000_0000_0100,
      S_WALK_L   = 12'b0000_0000_1000,
      S_WALK_E   = 12'b0000_0001_0000,
      S_DECIDE   = 12'b0000_0010_0000,
      S_MK_TAG   = 12'b0000_0100_0000,
      S_MK_LEN   = 12'b0000_1000_0000,
      S_WBYTE    = 12'b0001_0000_0000,
      S_RD_ISSUE = 12'b0010_0000_0000,
      S_RD_PUSH  = 12'b0100_0000_0000,
      S_PUSH1    = 12'b1000_0000_0000
   } state_type;

   function automatic logic [5:0] grant(input logic [7:0] len, input logic [7:0] off,
                                        input logic [5:0] cnt);
      logic [8:0] reach;
      reach = {1'b0, off} + {3'b000, cnt};
      if (off > len) begin
         return 6'd0;
      end else if (reach > {1'b0, len}) begin
         return 6'(len - off);
      end
      return cnt;
   endfunction

   state_type     state_ff, state_in;
   req_type       item_ff, item_in;
   logic [PW-1:0] at_ff, at_in;
   logic [7:0]    tag_seen_ff, tag_seen_in;
   logic          found_ff, found_in;
   logic          erased_ff, erased_in;
   logic [7:0]    len_ff, len_in;
   logic [5:0]    nbytes_ff, nbytes_in;
   logic [5:0]    idx_ff, idx_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          erase_ff, erase_in;
   logic [AW-1:0] base_ff, base_in;
   logic [5:0]    gl_ff, gl_in;
   logic [5:0]    pend_len_ff, pend_len_in;
   logic          pend_last_ff, pend_last_in;

   logic [5:0]    cnt_sat;
   logic [PW-1:0] hdr_end;
   logic [7:0]    clip_len;
   logic [PW-1:0] wr_addr;
   logic [5:0]    found_grant;
   logic [5:0]    made_grant;

   logic          in_walk;
   logic          rd_final;
   logic          clr_done;
   logic          erase_ack;

   assign cnt_sat     = (item_ff.count > MAX_CNT) ? MAX_CNT : item_ff.count;
   assign hdr_end     = at_ff + PW'(2) + PW'(mem_rdata);
   // a record running past the end keeps only the bytes that remain
   assign clip_len    = (hdr_end > MEM_END) ? 8'(MEM_END - at_ff - PW'(2)) : mem_rdata;
   assign wr_addr     = PW'(base_ff) + PW'(2) + PW'(item_ff.offset) + PW'(item_ff.byte_index);
   assign found_grant = grant(len_ff, item_ff.offset, cnt_sat);
   assign made_grant  = grant(item_ff.param_len, item_ff.offset, cnt_sat);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      at_in        = at_ff;
      tag_seen_in  = tag_seen_ff;
      found_in     = found_ff;
      erased_in    = erased_ff;
      len_in       = len_ff;
      nbytes_in    = nbytes_ff;
      idx_in       = idx_ff;
      rd_addr_in   = rd_addr_ff;
      clr_in       = clr_ff;
      erase_in     = erase_ff;
      base_in      = base_ff;
      gl_in        = gl_ff;
      pend_len_in  = pend_len_ff;
      pend_last_in = pend_last_ff;
      mem_ctl      = '0;
      mem_addr     = '0;
      mem_wdata    = ERASED_TAG;
      rsp_load     = 1'b0;
      rsp_next     = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_ff;
            mem_wdata     = ERASED_TAG;
            clr_in        = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               clr_in = '0;
               if (erase_ff) begin
                  erase_in     = 1'b0;
                  pend_len_in  = '0;
                  pend_last_in = 1'b1;
                  state_in     = S_PUSH1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               item_in   = req_word;
               at_in     = '0;
               found_in  = 1'b0;
               erased_in = 1'b0;
               case (req_word.cmd)
                  CMD_READ: begin
                     if (req_word.tag == ERASED_TAG) begin
                        pend_len_in  = '0;
                        pend_last_in = 1'b1;
                        state_in     = S_PUSH1;
                     end else begin
                        state_in = S_WALK_T;
                     end
                  end
                  CMD_WRITE: begin
                     if (req_word.byte_index != '0) begin
                        state_in = S_WBYTE;
                     end else if (req_word.tag == ERASED_TAG) begin
                        base_in  = '0;
                        gl_in    = '0;
                        state_in = S_WBYTE;
                     end else begin
                        state_in = S_WALK_T;
                     end
                  end
                  CMD_ERASE: begin
                     base_in  = '0;
                     gl_in    = '0;
                     clr_in   = '0;
                     erase_in = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_WALK_T: begin
            if ((at_ff + PW'(1)) >= MEM_END) begin
               state_in = S_DECIDE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_addr      = at_ff[AW-1:0];
               state_in      = S_WALK_L;
            end
         end

         S_WALK_L: begin
            tag_seen_in   = mem_rdata;
            mem_ctl.rd_en = 1'b1;
            mem_addr      = AW'(at_ff + PW'(1));
            state_in      = S_WALK_E;
         end

         S_WALK_E: begin
            if (tag_seen_ff == item_ff.tag) begin
               found_in = 1'b1;
               len_in   = clip_len;
               state_in = S_DECIDE;
            end else if (tag_seen_ff == ERASED_TAG) begin
               erased_in = 1'b1;
               len_in    = clip_len;
               state_in  = S_DECIDE;
            end else begin
               at_in    = hdr_end;
               state_in = S_WALK_T;
            end
         end

         S_DECIDE: begin
            if (item_ff.cmd == CMD_READ) begin
               if (!found_ff || found_grant == '0) begin
                  pend_len_in  = '0;
                  pend_last_in = 1'b1;
                  state_in     = S_PUSH1;
               end else begin
                  nbytes_in  = found_grant;
                  idx_in     = '0;
                  rd_addr_in = AW'(at_ff + PW'(2) + PW'(item_ff.offset));
                  state_in   = S_RD_ISSUE;
               end
            end else begin
               state_in = S_WBYTE;
               if (found_ff) begin
                  base_in = at_ff[AW-1:0];
                  gl_in   = found_grant;
               end else if (erased_ff) begin
                  base_in = at_ff[AW-1:0];
                  gl_in   = '0;
                  // new record only when the whole value is written at once and fits in the free space
                  if (item_ff.param_len == {2'b00, cnt_sat} && len_ff > item_ff.param_len) begin
                     gl_in    = made_grant;
                     state_in = S_MK_TAG;
                  end
               end else begin
                  base_in = '0;
                  gl_in   = '0;
               end
            end
         end

         S_MK_TAG: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = base_ff;
            mem_wdata     = item_ff.tag;
            state_in      = S_MK_LEN;
         end

         S_MK_LEN: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = base_ff + AW'(1);
            mem_wdata     = item_ff.param_len;
            state_in      = S_WBYTE;
         end

         S_WBYTE: begin
            if ({1'b0, item_ff.byte_index} < gl_ff && wr_addr < MEM_END) begin
               mem_ctl.wr_en = 1'b1;
               mem_addr      = wr_addr[AW-1:0];
               mem_wdata     = item_ff.data;
            end
            pend_len_in  = gl_ff;
            pend_last_in = ({1'b0, item_ff.byte_index} + 6'd1) >= cnt_sat;
            state_in     = S_PUSH1;
         end

         S_RD_ISSUE: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = rd_addr_ff;
            state_in      = S_RD_PUSH;
         end

         S_RD_PUSH: begin
            if (rsp_slot_free) begin
               rsp_load          = 1'b1;
               rsp_next.data_res = mem_rdata;
               rsp_next.length   = nbytes_ff;
               rsp_next.last     = (idx_ff + 6'd1) == nbytes_ff;
               idx_in            = idx_ff + 6'd1;
               rd_addr_in        = rd_addr_ff + AW'(1);
               state_in          = ((idx_ff + 6'd1) == nbytes_ff) ? S_IDLE : S_RD_ISSUE;
            end
         end

         S_PUSH1: begin
            if (rsp_slot_free) begin
               rsp_load        = 1'b1;
               rsp_next.length = pend_len_ff;
               rsp_next.last   = pend_last_ff;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         erase_ff <= 1'b0;
         base_ff  <= '0;
         gl_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         erase_ff <= erase_in;
         base_ff  <= base_in;
         gl_ff    <= gl_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      at_ff        <= at_in;
      tag_seen_ff  <= tag_seen_in;
      found_ff     <= found_in;
      erased_ff    <= erased_in;
      len_ff       <= len_in;
      nbytes_ff    <= nbytes_in;
      idx_ff       <= idx_in;
      rd_addr_ff   <= rd_addr_in;
      pend_len_ff  <= pend_len_in;
      pend_last_ff <= pend_last_in;
   end

   assign in_walk   = (state_ff == S_WALK_T) || (state_ff == S_WALK_L) ||
                      (state_ff == S_WALK_E) || (state_ff == S_DECIDE);
   assign rd_final  = (state_ff == S_RD_PUSH) && rsp_load && rsp_next.last;
   assign clr_done  = (state_ff == S_CLEAR) && (clr_ff == LAST_ADDR) && erase_ff;
   assign erase_ack = (state_ff == S_PUSH1) && pend_last_ff && (pend_len_ff == 6'd0);

   `TLVPS_ASSERT_IMPL(a_load_needs_slot, clock, reset, rsp_load, rsp_slot_free)
   `TLVPS_ASSERT_IMPL(a_walk_no_write, clock, reset, in_walk, !mem_ctl.wr_en)
   `TLVPS_ASSERT_IMPL(a_read_in_range, clock, reset, state_ff == S_RD_ISSUE, idx_ff < nbytes_ff)
   `TLVPS_ASSERT_NEXT(a_read_ends_idle, clock, reset, rd_final, state_ff == S_IDLE)
   `TLVPS_ASSERT_NEXT(a_erase_reply, clock, reset, clr_done, erase_ack)

endmodule

`default_nettype wire

### test/tlv_parameter_store_top_tb.sv
`timescale 1ns / 100ps

module tlv_parameter_store_top_tb;
   import tlvps_pkg::*;

   localparam int STORE_BYTES = MEM_BYTES_DEF;
   localparam int RANDOM_WORDS = 300;
   localparam int HOLD_CYCLES = 200;
   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 100;
   localparam rsp_type EMPTY_LAST = {8'h00, 6'd0, 1'b1};
   localparam rsp_type EMPTY_MORE = {8'h00, 6'd0, 1'b0};

   typedef struct packed {
      req_type word;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_word = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_word;

   // shadow of the block state
   logic [7:0]  shadow_mem [0:STORE_BYTES-1];
   int unsigned rec_base;
   int unsigned grant_len;

   rsp_type      pending_replies[$];
   stim_row_type dir_tab[$];
   int unsigned  fail_count = 0;
   int unsigned  useful_words = 0;
   bit           idle_on = 1'b1;
   bit           hold_req = 1'b0;

   tlv_parameter_store_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic req_type mk_req(input cmd_type c, input int unsigned tg,
                                      input int unsigned pl, input int unsigned off,
                                      input int unsigned cnt, input int unsigned bi,
                                      input int unsigned dat);
      req_type w;
      w.cmd = c;
      w.tag = tg[7:0];
      w.param_len = pl[7:0];
      w.offset = off[7:0];
      w.count = cnt[5:0];
      w.byte_index = bi[4:0];
      w.data = dat[7:0];
      return w;
   endfunction

   function automatic stim_row_type mk_row(input cmd_type c, input int unsigned tg,
                                           input int unsigned pl, input int unsigned off,
                                           input int unsigned cnt, input int unsigned bi,
                                           input int unsigned dat);
      stim_row_type s;
      s.word = mk_req(c, tg, pl, off, cnt, bi, dat);
      s.typed = 1'b0;
      s.want = '0;
      return s;
   endfunction

   function automatic stim_row_type with_reply(input stim_row_type s, input rsp_type r);
      s.typed = 1'b1;
      s.want = r;
      return s;
   endfunction

   // header walk from address 0; STORE_BYTES when the tag is absent
   function automatic int unsigned find_record(input logic [7:0] id,
                                               output int unsigned vlen);
      int unsigned at;
      int unsigned hlen;
      at = 0;
      vlen = 0;
      while (at + 1 < STORE_BYTES) begin
         hlen = shadow_mem[at + 1];
         if (shadow_mem[at] == id) begin
            if (at + 2 + hlen > STORE_BYTES) hlen = STORE_BYTES - at - 2;
            vlen = hlen;
            return at;
         end
         if (shadow_mem[at] == ERASED_TAG) break;
         at += 2 + hlen;
      end
      return STORE_BYTES;
   endfunction

   function automatic int unsigned grant_bytes(input int unsigned vlen,
                                               input int unsigned off,
                                               input int unsigned cnt);
      if (off > vlen) return 0;
      if (off + cnt > vlen) return vlen - off;
      return cnt;
   endfunction

   task automatic compute_replies(input req_type w, input bit keep);
      rsp_type     outs[$];
      rsp_type     r;
      int unsigned cnt, off, vlen, at, n, a, i;
      cnt = w.count;
      if (cnt > MAX_TRANSFER) cnt = MAX_TRANSFER;
      off = w.offset;
      n = 0;
      at = STORE_BYTES;
      vlen = 0;
      case (w.cmd)
         CMD_READ: begin
            if (w.tag != ERASED_TAG) begin
               at = find_record(w.tag, vlen);
               if (at < STORE_BYTES) n = grant_bytes(vlen, off, cnt);
            end
            if (n == 0) outs.push_back(EMPTY_LAST);
            for (i = 0; i < n; i++) begin
               a = at + 2 + off + i;
               r.data_res = (a < STORE_BYTES) ? shadow_mem[a] : 8'h00;
               r.length = n[5:0];
               r.last = (i + 1 == n);
               outs.push_back(r);
            end
         end
         CMD_WRITE: begin
            if (w.byte_index == 0) begin
               if (w.tag != ERASED_TAG) begin
                  at = find_record(w.tag, vlen);
                  // absent record: create it in free space if it fits
                  if (at >= STORE_BYTES && w.param_len == cnt) begin
                     at = find_record(ERASED_TAG, vlen);
                     if (at < STORE_BYTES && vlen > w.param_len) begin
                        shadow_mem[at] = w.tag;
                        shadow_mem[at + 1] = w.param_len;
                        vlen = w.param_len;
                     end else begin
                        vlen = 0;
                     end
                  end
                  if (at < STORE_BYTES) n = grant_bytes(vlen, off, cnt);
               end
               rec_base = (at < STORE_BYTES) ? at : 0;
               grant_len = n;
            end
            if (w.byte_index < grant_len) begin
               a = rec_base + 2 + off + w.byte_index;
               if (a < STORE_BYTES) shadow_mem[a] = w.data;
            end
            r.data_res = 8'h00;
            r.length = grant_len[5:0];
            r.last = (w.byte_index + 1 >= cnt);
            outs.push_back(r);
         end
         CMD_ERASE: begin
            foreach (shadow_mem[k]) shadow_mem[k] = ERASED_TAG;
            rec_base = 0;
            grant_len = 0;
            outs.push_back(EMPTY_LAST);
         end
         default: ;
      endcase
      if (keep) foreach (outs[k]) pending_replies.push_back(outs[k]);
   endtask

   task automatic send_word(input req_type w, input bit keep);
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      compute_replies(w, keep);
      if (w.cmd != CMD_NONE) useful_words++;
   endtask

   task automatic sender_gap();
      int unsigned n;
      n = 0;
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      if (idle_on && $urandom_range(0, 99) < 25)
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   function automatic int unsigned pick_tag();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(0, 11);
      if (roll < 95) return $urandom_range(0, 254);
      return ERASED_TAG;
   endfunction

   function automatic int unsigned pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 6);
      if (roll < 95) return $urandom_range(7, 32);
      return $urandom_range(33, 63);
   endfunction

   function automatic int unsigned pick_offset();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 90) return $urandom_range(1, 8);
      return $urandom_range(0, 255);
   endfunction

   task automatic random_request();
      int unsigned kind, tg, cnt, off, pl, items, k;
      kind = $urandom_range(0, 99);
      tg = pick_tag();
      cnt = pick_count();
      off = pick_offset();
      items = (cnt == 0) ? 1 : ((cnt > MAX_TRANSFER) ? MAX_TRANSFER : cnt);
      if (kind < 42) begin
         // whole write request, param_len mostly matching so records get created
         pl = ($urandom_range(0, 3) != 0) ? ((cnt > MAX_TRANSFER) ? MAX_TRANSFER : cnt)
                                          : $urandom_range(0, 255);
         for (k = 0; k < items; k++) begin
            send_word(mk_req(CMD_WRITE, tg, pl, off, cnt, k, $urandom_range(0, 255)), 1);
            sender_gap();
         end
      end else if (kind < 78) begin
         send_word(mk_req(CMD_READ, tg, $urandom_range(0, 255), off, cnt,
                          $urandom_range(0, 31), $urandom_range(0, 255)), 1);
         sender_gap();
      end else if (kind < 82) begin
         send_word(mk_req(CMD_ERASE, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 63),
                          $urandom_range(0, 31), $urandom_range(0, 255)), 1);
         sender_gap();
      end else if (kind < 88) begin
         send_word(mk_req(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 63),
                          $urandom_range(0, 31), $urandom_range(0, 255)), 1);
         sender_gap();
      end else begin
         // broken write: skipped starts, offset and tag changes mid-request
         items = $urandom_range(1, 6);
         k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
         repeat (items) begin
            if ($urandom_range(0, 2) == 0) off = $urandom_range(0, 255);
            if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 31);
            if ($urandom_range(0, 5) == 0) tg = $urandom_range(0, 255);
            send_word(mk_req(CMD_WRITE, tg, $urandom_range(0, 255), off, cnt, k,
                             $urandom_range(0, 255)), 1);
            sender_gap();
            k = (k + 1) % 32;
         end
      end
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      if (pending_replies.size() == 0) begin
         $display("%0t: unexpected word: expected none, actual data_res=%h length=%0d last=%b",
                  $time, got.data_res, got.length, got.last);
         fail_count++;
      end else begin
         want = pending_replies.pop_front();
         if (got.data_res !== want.data_res) begin
            $display("%0t: data_res: expected %h, actual %h", $time, want.data_res,
                     got.data_res);
            fail_count++;
         end
         if (got.length !== want.length) begin
            $display("%0t: length: expected %0d, actual %0d", $time, want.length, got.length);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last: expected %b, actual %b", $time, want.last, got.last);
            fail_count++;
         end
      end
   endtask

   initial begin : request_side
      int unsigned lv, rtag, random_goal;
      bit          paused;
      foreach (shadow_mem[k]) shadow_mem[k] = ERASED_TAG;
      rec_base = 0;
      grant_len = 0;
      paused = 1'b0;

      // write byte with no start, then absent and reserved tags
      dir_tab.push_back(with_reply(mk_row(CMD_WRITE, 8'h11, 3, 0, 3, 2, 8'hAB), EMPTY_LAST));
      dir_tab.push_back(with_reply(mk_row(CMD_READ, 8'h11, 0, 0, 4, 0, 0), EMPTY_LAST));
      dir_tab.push_back(with_reply(mk_row(CMD_READ, ERASED_TAG, 0, 0, 32, 0, 0), EMPTY_LAST));
      dir_tab.push_back(with_reply(mk_row(CMD_WRITE, ERASED_TAG, 0, 0, 0, 0, 0), EMPTY_LAST));
      dir_tab.push_back(mk_row(CMD_NONE, 8'hFF, 8'hFF, 8'hFF, 63, 31, 8'hFF));
      // chain of records whose trailing header is forged with length 0xFF, each one
      // pushing free space 261 bytes further, up to 783
      for (lv = 0; lv < 4; lv++) begin
         rtag = (lv == 3) ? 8'hFE : 2 * lv;
         dir_tab.push_back(mk_row(CMD_WRITE, rtag, 2, 0, 2, 0, 8'h00));
         if (lv == 3)
            dir_tab.push_back(mk_row(CMD_WRITE, rtag, 2, 255, 2, 1, 8'h77));
         dir_tab.push_back(mk_row(CMD_WRITE, rtag, 2, 1, 2, 1, 2 * lv + 1));
         dir_tab.push_back(mk_row(CMD_WRITE, rtag, 2, 2, 2, 1, 8'hFF));
      end
      // header at 787 runs past the end: clipped length, count saturates
      dir_tab.push_back(mk_row(CMD_READ, 7, 0, 0, 63, 0, 0));
      dir_tab.push_back(with_reply(mk_row(CMD_READ, 0, 0, 5, 4, 0, 0), EMPTY_LAST));
      dir_tab.push_back(mk_row(CMD_READ, 0, 0, 1, 32, 0, 0));
      dir_tab.push_back(with_reply(mk_row(CMD_WRITE, 8'h30, 8'hFF, 0, 32, 0, 0), EMPTY_MORE));
      dir_tab.push_back(with_reply(mk_row(CMD_ERASE, 0, 0, 0, 0, 0, 0), EMPTY_LAST));
      dir_tab.push_back(with_reply(mk_row(CMD_WRITE, 0, 0, 0, 32, 31, 8'h55), EMPTY_LAST));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[k]) begin
         send_word(dir_tab[k].word, !dir_tab[k].typed);
         if (dir_tab[k].typed) pending_replies.push_back(dir_tab[k].want);
         sender_gap();
      end
      drain_replies();

      // receiver holds off while requests keep coming
      hold_req = 1'b1;
      random_goal = useful_words + RANDOM_WORDS;
      while (useful_words < random_goal) begin
         if (!paused && useful_words + RANDOM_WORDS / 2 >= random_goal) begin
            drain_replies();
            paused = 1'b1;
         end
         random_request();
      end

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : reply_side
      int unsigned stall_left, roll;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) check_reply(rsp_word);
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && idle_on) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) stall_left = $urandom_range(10, 40);
            else if (roll < 30) stall_left = $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### tlv_parameter_store_top.f
+incdir+rtl
rtl/tlvps_pkg.sv
rtl/tlvps_mem.sv
rtl/tlvps_out.sv
rtl/tlvps_ctrl.sv
rtl/tlv_parameter_store_top.sv
test/tlv_parameter_store_top_tb.sv
